/* sv/decimal_text_to_integer_assert.svh */
// Assertion macros shared by the decimal text parser modules.
// Each macro expects clk_i to be visible where it is used; DTTI_ASSERT also expects rst_ni.
`ifndef DECIMAL_TEXT_TO_INTEGER_ASSERT_SVH
`define DECIMAL_TEXT_TO_INTEGER_ASSERT_SVH

// Checked only while out of reset.
`define DTTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define DTTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/dtti_pkg.sv */
`default_nettype none

package dtti_pkg;

  // Character codes, compared after zero extension to 32 bits
  localparam logic [31:0] CodeZero  = 32'd48;
  localparam logic [31:0] CodeNine  = 32'd57;
  localparam logic [31:0] CodeMinus = 32'd45;
  localparam logic [31:0] CodePlus  = 32'd43;

  // Configuration port
  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CfgSpaceA = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgSpaceB = 8'd1;

  localparam logic [CfgDataWidth-1:0] SpaceAReset = 16'd32;
  localparam logic [CfgDataWidth-1:0] SpaceBReset = 16'd9;

  typedef enum logic [2:0] {
    PhLead,
    PhSign,
    PhDigits,
    PhTrail,
    PhBad
  } phase_e;

  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic       is_minus;
    logic       is_plus;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic valid_res;
    logic is_number;
    logic overflow;
  } res_flags_t;

endpackage

`default_nettype wire

/* sv/dtti_intf.sv */
`default_nettype none

interface dtti_in_if #(
  parameter int unsigned CHAR_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] char_code;
  logic                  has_char;
  logic                  last;

  modport source (output valid, char_code, has_char, last, input ready);
  modport sink   (input valid, char_code, has_char, last, output ready);
endinterface

interface dtti_out_if #(
  parameter int unsigned VALUE_WIDTH = 64
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          valid_res;
  logic                          is_number;
  logic                          overflow;

  modport source (output valid, value, valid_res, is_number, overflow, input ready);
  modport sink   (input valid, value, valid_res, is_number, overflow, output ready);
endinterface

interface dtti_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dtti_pkg::CfgIdxWidth-1:0]  index;
  logic [dtti_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/dtti_char_class.sv */
`default_nettype none

module dtti_char_class #(
  parameter int unsigned CHAR_WIDTH = 16
) (
  input  wire logic [CHAR_WIDTH-1:0]               char_code_i,
  input  wire logic [dtti_pkg::CfgDataWidth-1:0]   space_a_i,
  input  wire logic [dtti_pkg::CfgDataWidth-1:0]   space_b_i,
  output dtti_pkg::char_class_t                    class_o
);

  logic [31:0]           code32;
  logic [31:0]           space_a32;
  logic [31:0]           space_b32;
  logic [CHAR_WIDTH-1:0] space_a;
  logic [CHAR_WIDTH-1:0] space_b;

  // Space codes are compared in the low CHAR_WIDTH bits only
  assign code32    = 32'(char_code_i);
  assign space_a32 = 32'(space_a_i);
  assign space_b32 = 32'(space_b_i);
  assign space_a   = space_a32[CHAR_WIDTH-1:0];
  assign space_b   = space_b32[CHAR_WIDTH-1:0];

  always_comb begin
    class_o.is_space = (char_code_i == space_a) || (char_code_i == space_b);
    class_o.is_digit = (code32 >= dtti_pkg::CodeZero) && (code32 <= dtti_pkg::CodeNine);
    class_o.is_minus = (code32 == dtti_pkg::CodeMinus);
    class_o.is_plus  = (code32 == dtti_pkg::CodePlus);
    // '0' sits at 0x30, so the low nibble is the digit value
    class_o.digit    = code32[3:0];
  end

endmodule

`default_nettype wire

/* sv/dtti_parse_core.sv */
`default_nettype none
`include "decimal_text_to_integer_assert.svh"

module dtti_parse_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          has_char_i,
  input  wire logic                          last_i,
  input  wire dtti_pkg::char_class_t         class_i,
  output logic signed [VALUE_WIDTH-1:0]      value_o,
  output dtti_pkg::res_flags_t               flags_o
);

  localparam int unsigned MagWidth = VALUE_WIDTH - 1;
  localparam int unsigned AccWidth = VALUE_WIDTH + 3;
  localparam logic [MagWidth-1:0] MaxMag = {MagWidth{1'b1}};

  dtti_pkg::phase_e    phase_q, phase_d, phase_c;
  logic                neg_q, neg_d, neg_c;
  logic [MagWidth-1:0] mag_q, mag_d, mag_c;
  logic                sat_q, sat_d, sat_c;

  logic [AccWidth-1:0] acc;
  logic                acc_ovf;
  logic [MagWidth-1:0] mag_add;
  logic                sat_add;
  logic [VALUE_WIDTH-1:0] mag_ext;

  // magnitude * 10 + digit, checked against the largest positive value
  assign acc     = (AccWidth'(mag_q) << 3) + (AccWidth'(mag_q) << 1)
                 + AccWidth'(class_i.digit);
  assign acc_ovf = sat_q || (acc > AccWidth'(MaxMag));
  assign mag_add = acc_ovf ? MaxMag : acc[MagWidth-1:0];
  assign sat_add = acc_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dtti_pkg::PhLead;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      sat_q   <= sat_d;
    end
  end

  always_comb begin
    phase_c = phase_q;
    neg_c   = neg_q;
    mag_c   = mag_q;
    sat_c   = sat_q;
    if (has_char_i) begin
      case (phase_q)
        dtti_pkg::PhLead: begin
          // space wins over sign and digit here
          if (class_i.is_space) begin
            phase_c = dtti_pkg::PhLead;
          end else if (class_i.is_minus) begin
            neg_c   = 1'b1;
            phase_c = dtti_pkg::PhSign;
          end else if (class_i.is_plus) begin
            phase_c = dtti_pkg::PhSign;
          end else if (class_i.is_digit) begin
            mag_c   = mag_add;
            sat_c   = sat_add;
            phase_c = dtti_pkg::PhDigits;
          end else begin
            phase_c = dtti_pkg::PhBad;
          end
        end
        dtti_pkg::PhSign: begin
          if (class_i.is_digit) begin
            mag_c   = mag_add;
            sat_c   = sat_add;
            phase_c = dtti_pkg::PhDigits;
          end else begin
            phase_c = dtti_pkg::PhBad;
          end
        end
        dtti_pkg::PhDigits: begin
          // digit wins over space once digits have started
          if (class_i.is_digit) begin
            mag_c = mag_add;
            sat_c = sat_add;
          end else if (class_i.is_space) begin
            phase_c = dtti_pkg::PhTrail;
          end else begin
            phase_c = dtti_pkg::PhBad;
          end
        end
        dtti_pkg::PhTrail: begin
          if (!class_i.is_space) begin
            phase_c = dtti_pkg::PhBad;
          end
        end
        default: begin
          phase_c = dtti_pkg::PhBad;
        end
      endcase
    end

    // hold unless an item steps through; restart the parse after the last item
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    sat_d   = sat_q;
    if (step_i) begin
      if (last_i) begin
        phase_d = dtti_pkg::PhLead;
        neg_d   = 1'b0;
        mag_d   = '0;
        sat_d   = 1'b0;
      end else begin
        phase_d = phase_c;
        neg_d   = neg_c;
        mag_d   = mag_c;
        sat_d   = sat_c;
      end
    end
  end

  // Result as seen after this item is consumed
  assign mag_ext = {1'b0, mag_c};

  always_comb begin
    value_o           = '0;
    flags_o.valid_res = 1'b0;
    flags_o.is_number = 1'b0;
    flags_o.overflow  = 1'b0;
    case (phase_c)
      dtti_pkg::PhLead: begin
        flags_o.valid_res = 1'b1;
      end
      dtti_pkg::PhDigits, dtti_pkg::PhTrail: begin
        value_o           = neg_c ? $signed('0 - mag_ext) : $signed(mag_ext);
        flags_o.valid_res = 1'b1;
        flags_o.is_number = 1'b1;
        flags_o.overflow  = sat_c;
      end
      default: begin
        value_o = '0;
      end
    endcase
  end

  `DTTI_ASSERT(a_sat_pins_max,
               sat_q |-> (mag_q == MaxMag),
               "saturated magnitude not at maximum")
  `DTTI_ASSERT(a_lead_is_clean,
               (phase_q == dtti_pkg::PhLead) |-> (mag_q == '0 && !neg_q && !sat_q),
               "leading phase carries stale sign or magnitude")

endmodule

`default_nettype wire

/* sv/decimal_text_to_integer.sv */
// Flow: an accepted item waits in the input register and is parsed as it steps out;
//   a string's result is loaded into the result register at that same step.
// Throughput: one item per cycle, set by the multiply-by-ten-and-add step that
//   updates the magnitude; stalls only when a result waits unaccepted.
// Reset: space codes return to 32 and 9, the parser to its leading-space phase,
//   and both the item and result registers empty.
`default_nettype none
`include "decimal_text_to_integer_assert.svh"

module decimal_text_to_integer #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned CHAR_WIDTH  = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dtti_cfg_if.sink     cfg_i,
  dtti_in_if.sink      in_i,
  dtti_out_if.source   out_o
);

  // Configuration registers: the two codes skipped as space
  logic [dtti_pkg::CfgDataWidth-1:0] space_a_q;
  logic [dtti_pkg::CfgDataWidth-1:0] space_b_q;

  // Input register holding one item
  logic                  iv_q;
  logic [CHAR_WIDTH-1:0] char_q;
  logic                  has_q;
  logic                  last_q;

  // Result register
  logic                          ov_q;
  logic signed [VALUE_WIDTH-1:0] value_q;
  dtti_pkg::res_flags_t          flags_q;

  logic                          out_free;
  logic                          adv;
  logic                          in_take;
  dtti_pkg::char_class_t         char_class;
  logic signed [VALUE_WIDTH-1:0] res_value;
  dtti_pkg::res_flags_t          res_flags;

  // Writes are to arrive only while idle; the block does not enforce this, and the port is always open
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_a_q <= dtti_pkg::SpaceAReset;
      space_b_q <= dtti_pkg::SpaceBReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dtti_pkg::CfgSpaceA: space_a_q <= cfg_i.data;
        dtti_pkg::CfgSpaceB: space_b_q <= cfg_i.data;
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // An item that ends a string needs room in the result register;
  // any other item steps through the parser without waiting.
  assign out_free   = !ov_q || out_o.ready;
  assign adv        = iv_q && (!last_q || out_free);
  assign in_i.ready = !iv_q || adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_take) begin
      iv_q <= 1'b1;
    end else if (adv) begin
      iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= in_i.char_code;
      has_q  <= in_i.has_char;
      last_q <= in_i.last;
    end
  end

  dtti_char_class #(
    .CHAR_WIDTH (CHAR_WIDTH)
  ) u_class (
    .char_code_i (char_q),
    .space_a_i   (space_a_q),
    .space_b_i   (space_b_q),
    .class_o     (char_class)
  );

  dtti_parse_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .has_char_i (has_q),
    .last_i     (last_q),
    .class_i    (char_class),
    .value_o    (res_value),
    .flags_o    (res_flags)
  );

  // Load a result when the last item of a string steps; clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv && last_q) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      value_q <= res_value;
      flags_q <= res_flags;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.value     = value_q;
  assign out_o.valid_res = flags_q.valid_res;
  assign out_o.is_number = flags_q.is_number;
  assign out_o.overflow  = flags_q.overflow;

  `DTTI_ASSERT(a_invalid_is_zero,
               (ov_q && !flags_q.valid_res) |-> (value_q == '0),
               "invalid result with nonzero value")
  `DTTI_ASSERT(a_ovf_needs_number,
               (ov_q && flags_q.overflow) |-> flags_q.is_number,
               "overflow flagged without a number")
  `DTTI_ASSERT(a_item_held,
               (iv_q && !adv) |=> iv_q,
               "stalled item lost from input register")
  `DTTI_ASSERT_ALWAYS(a_reset_empty,
                      !rst_ni |-> !ov_q,
                      "result offered during reset")

endmodule

`default_nettype wire
